// ----- hw/rtl/swe_pkg.sv -----
// swe_pkg: shared constants, types and lookup tables for the sliding window entropy block
// no dependencies; used by the interfaces and every module of the block

package swe_pkg;

    localparam int RES_W          = 8;
    localparam int CODE_W         = 5;
    localparam int NLETTERS       = 20;
    localparam int CNT_W          = 4;
    localparam int CNT_MAX        = 15;
    localparam int ENT_W          = 18;
    localparam int CUT_W          = 18;
    localparam int FRAC_W         = 16;
    localparam int SUM_W          = 38;
    localparam int NUM_W          = 39;
    localparam int DIV_W          = NUM_W - FRAC_W;
    localparam int STEP_W         = 5;
    localparam int WINDOW_DEFAULT = 12;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_IDX_W      = 1;

    typedef logic [CODE_W-1:0]    t_code;
    typedef logic [CNT_W-1:0]     t_count;
    typedef logic [SUM_W-1:0]     t_sum;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_code NOT_COUNTED = t_code'(20);

    localparam t_cfg_idx CFG_TRIGGER_CUT = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_EXTEND_CUT  = t_cfg_idx'(1);

    localparam logic [CUT_W-1:0] TRIGGER_CUT_RST = CUT_W'(144179);
    localparam logic [CUT_W-1:0] EXTEND_CUT_RST  = CUT_W'(163840);

    typedef struct packed {
        t_code code;
        logic  seq_start;
    } t_swe_item;

    typedef struct packed {
        logic [CUT_W-1:0] trigger_cut;
        logic [CUT_W-1:0] extend_cut;
    } t_swe_cuts;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_INC,
        ST_NUM,
        ST_RND,
        ST_DIV,
        ST_DONE
    } t_back_state;

    // letter code of a residue byte, lower case folded
    function automatic t_code code_of(input logic [RES_W-1:0] b);
        logic [RES_W-1:0] u;
        t_code            c;
        u = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
        unique case (u)
            8'h41:   c = t_code'(0);   // A
            8'h43:   c = t_code'(1);   // C
            8'h44:   c = t_code'(2);   // D
            8'h45:   c = t_code'(3);   // E
            8'h46:   c = t_code'(4);   // F
            8'h47:   c = t_code'(5);   // G
            8'h48:   c = t_code'(6);   // H
            8'h49:   c = t_code'(7);   // I
            8'h4B:   c = t_code'(8);   // K
            8'h4C:   c = t_code'(9);   // L
            8'h4D:   c = t_code'(10);  // M
            8'h4E:   c = t_code'(11);  // N
            8'h50:   c = t_code'(12);  // P
            8'h51:   c = t_code'(13);  // Q
            8'h52:   c = t_code'(14);  // R
            8'h53:   c = t_code'(15);  // S
            8'h54:   c = t_code'(16);  // T
            8'h56:   c = t_code'(17);  // V
            8'h57:   c = t_code'(18);  // W
            8'h59:   c = t_code'(19);  // Y
            default: c = NOT_COUNTED;
        endcase
        return c;
    endfunction

    // n * log2(n) * 2^32
    function automatic t_sum plog(input t_count n);
        t_sum v;
        unique case (n)
            4'd0:    v = 38'd0;
            4'd1:    v = 38'd0;
            4'd2:    v = 38'd8589934592;
            4'd3:    v = 38'd20422086318;
            4'd4:    v = 38'd34359738368;
            4'd5:    v = 38'd49863026155;
            4'd6:    v = 38'd66613976412;
            4'd7:    v = 38'd84402483053;
            4'd8:    v = 38'd103079215104;
            4'd9:    v = 38'd122532517908;
            4'd10:   v = 38'd142675725270;
            4'd11:   v = 38'd163439602315;
            4'd12:   v = 38'd184767560376;
            4'd13:   v = 38'd206612478410;
            4'd14:   v = 38'd228934508250;
            4'd15:   v = 38'd251699510055;
            default: v = '0;
        endcase
        return v;
    endfunction

    // plog(n) - plog(n-1), step of the running sum when a count moves between n-1 and n
    function automatic t_sum plog_step(input t_count n);
        t_sum v;
        unique case (n)
            4'd0:    v = 38'd0;
            4'd1:    v = 38'd0;
            4'd2:    v = 38'd8589934592;
            4'd3:    v = 38'd11832151726;
            4'd4:    v = 38'd13937652050;
            4'd5:    v = 38'd15503287787;
            4'd6:    v = 38'd16750950257;
            4'd7:    v = 38'd17788506641;
            4'd8:    v = 38'd18676732051;
            4'd9:    v = 38'd19453302804;
            4'd10:   v = 38'd20143207362;
            4'd11:   v = 38'd20763877045;
            4'd12:   v = 38'd21327958061;
            4'd13:   v = 38'd21844918034;
            4'd14:   v = 38'd22322029840;
            4'd15:   v = 38'd22765001805;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/swe_in_if.sv -----
// swe_in_if: residue input channel, valid/ready with residue byte and sequence start
// depends on swe_pkg

interface swe_in_if;
    logic                       valid;
    logic                       ready;
    logic [swe_pkg::RES_W-1:0]  residue;
    logic                       seq_start;

    modport source (output valid, output residue, output seq_start, input ready);
    modport sink   (input valid, input residue, input seq_start, output ready);
endinterface

// ----- hw/rtl/swe_out_if.sv -----
// swe_out_if: result channel, valid/ready with window entropy and flags
// depends on swe_pkg

interface swe_out_if;
    logic                       valid;
    logic                       ready;
    logic [swe_pkg::ENT_W-1:0]  entropy_bits;
    logic                       window_full;
    logic                       is_trigger;
    logic                       is_high;

    modport source (output valid, output entropy_bits, output window_full,
                    output is_trigger, output is_high, input ready);
    modport sink   (input valid, input entropy_bits, input window_full,
                    input is_trigger, input is_high, output ready);
endinterface

// ----- hw/rtl/swe_front.sv -----
// swe_front: accepts residue transactions, maps each byte to a letter code and queues it
// depends on swe_pkg and swe_in_if

module swe_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    swe_in_if.sink              i_in,
    output logic                o_item_valid,
    output swe_pkg::t_swe_item  o_item,
    input  logic                i_item_ready
);

    localparam int DEPTH = swe_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    swe_pkg::t_swe_item r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               push, pop;
    swe_pkg::t_swe_item in_item;

    assign in_item.code      = swe_pkg::code_of(i_in.residue);
    assign in_item.seq_start = i_in.seq_start;

    assign i_in.ready   = (r_count != CNT_W'(DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];

    assign push = i_in.valid && i_in.ready;
    assign pop  = o_item_valid && i_item_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        priority if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

endmodule

// ----- hw/rtl/swe_back.sv -----
// swe_back: window shift line, letter counts, running log sum, serial divider and result register
// depends on swe_pkg and swe_out_if

module swe_back #(
    parameter int WINDOW = swe_pkg::WINDOW_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  swe_pkg::t_swe_item  i_item,
    output logic                o_item_ready,
    input  swe_pkg::t_swe_cuts  i_cuts,
    swe_out_if.source           o_res
);

    localparam int CW     = swe_pkg::CNT_W;
    localparam int NL     = swe_pkg::NLETTERS;
    localparam int SW     = swe_pkg::SUM_W;
    localparam int NW     = swe_pkg::NUM_W;
    localparam int DW     = swe_pkg::DIV_W;
    localparam int EW     = swe_pkg::ENT_W;
    localparam int FW     = swe_pkg::FRAC_W;
    localparam int STW    = swe_pkg::STEP_W;
    localparam logic [CW-1:0] WIN_CNT = CW'(WINDOW);

    swe_pkg::t_back_state r_state, n_state;
    swe_pkg::t_code       r_win [WINDOW];
    swe_pkg::t_code       n_win [WINDOW];
    swe_pkg::t_count      r_cnt [NL];
    swe_pkg::t_count      n_cnt [NL];
    logic [CW-1:0]        r_fill, n_fill;
    logic [CW-1:0]        r_total, n_total;
    swe_pkg::t_sum        r_sum, n_sum;
    swe_pkg::t_code       r_code, n_code;
    swe_pkg::t_code       r_old, n_old;
    logic [SW-1:0]        r_num, n_num;
    logic [DW-1:0]        r_div, n_div;
    logic [CW-1:0]        r_rem, n_rem;
    logic [STW-1:0]       r_step, n_step;
    logic                 r_out_valid, n_out_valid;
    logic [EW-1:0]        r_out_ent, n_out_ent;
    logic                 r_out_full, n_out_full;
    logic                 r_out_trig, n_out_trig;
    logic                 r_out_high, n_out_high;

    swe_pkg::t_code       rd_addr;
    logic                 rd_counted;
    swe_pkg::t_count      rd_cnt;
    swe_pkg::t_count      step_idx;
    swe_pkg::t_sum        step_val;
    swe_pkg::t_sum        full_plog;
    logic [NW-1:0]        rnd_sum;
    logic [CW:0]          rem_sh;
    logic [CW:0]          rem_diff;
    logic                 rem_ge;
    logic [EW-1:0]        ent_sat;
    logic                 full_now;
    logic                 load_out;

    // one count read per cycle: the leaving letter in ST_DEC, the entering one in ST_INC
    assign rd_addr    = (r_state == swe_pkg::ST_INC) ? r_code : r_old;
    assign rd_counted = (rd_addr < swe_pkg::t_code'(NL));
    assign rd_cnt     = rd_counted ? r_cnt[rd_addr] : '0;
    assign step_idx   = (r_state == swe_pkg::ST_INC) ? rd_cnt + CW'(1) : rd_cnt;
    assign step_val   = swe_pkg::plog_step(step_idx);
    assign full_plog  = swe_pkg::plog(r_total);

    // entropy numerator plus half the divisor, then drop the fraction scale
    assign rnd_sum = NW'(r_num) + (NW'(r_total) << (FW - 1));

    assign rem_sh   = {r_rem, r_div[DW-1]};
    assign rem_diff = rem_sh - {1'b0, r_total};
    assign rem_ge   = (rem_sh >= {1'b0, r_total});

    assign ent_sat  = (|r_div[DW-1:EW]) ? '1 : r_div[EW-1:0];
    assign full_now = (r_fill >= WIN_CNT);
    assign load_out = (r_state == swe_pkg::ST_DONE) && (!r_out_valid || o_res.ready);

    assign o_res.valid        = r_out_valid;
    assign o_res.entropy_bits = r_out_ent;
    assign o_res.window_full  = r_out_full;
    assign o_res.is_trigger   = r_out_trig;
    assign o_res.is_high      = r_out_high;

    always_comb begin
        n_state     = r_state;
        n_win       = r_win;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_total     = r_total;
        n_sum       = r_sum;
        n_code      = r_code;
        n_old       = r_old;
        n_num       = r_num;
        n_div       = r_div;
        n_rem       = r_rem;
        n_step      = r_step;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_ent   = r_out_ent;
        n_out_full  = r_out_full;
        n_out_trig  = r_out_trig;
        n_out_high  = r_out_high;
        o_item_ready = 1'b0;

        unique case (r_state)
            swe_pkg::ST_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    if (i_item.seq_start) begin
                        for (int k = 0; k < WINDOW; k++) begin
                            n_win[k] = swe_pkg::NOT_COUNTED;
                        end
                        for (int k = 0; k < NL; k++) begin
                            n_cnt[k] = '0;
                        end
                        n_fill  = '0;
                        n_total = '0;
                        n_sum   = '0;
                    end
                    n_old = n_win[WINDOW-1];
                    for (int k = WINDOW - 1; k > 0; k--) begin
                        n_win[k] = n_win[k-1];
                    end
                    n_win[0] = i_item.code;
                    if (n_fill < WIN_CNT) begin
                        n_fill = n_fill + CW'(1);
                    end
                    n_code  = i_item.code;
                    n_state = swe_pkg::ST_DEC;
                end
            end
            swe_pkg::ST_DEC: begin
                if (rd_counted && rd_cnt != '0) begin
                    n_cnt[rd_addr] = rd_cnt - CW'(1);
                    n_sum          = r_sum - step_val;
                    n_total        = r_total - CW'(1);
                end
                n_state = swe_pkg::ST_INC;
            end
            swe_pkg::ST_INC: begin
                if (rd_counted && rd_cnt != CW'(swe_pkg::CNT_MAX)) begin
                    n_cnt[rd_addr] = rd_cnt + CW'(1);
                    n_sum          = r_sum + step_val;
                    n_total        = r_total + CW'(1);
                end
                n_state = swe_pkg::ST_NUM;
            end
            swe_pkg::ST_NUM: begin
                n_num   = (full_plog > r_sum) ? full_plog - r_sum : '0;
                n_state = swe_pkg::ST_RND;
            end
            swe_pkg::ST_RND: begin
                n_rem  = '0;
                n_step = '0;
                if (r_total == '0) begin
                    n_div   = '0;
                    n_state = swe_pkg::ST_DONE;
                end else begin
                    n_div   = rnd_sum[NW-1:FW];
                    n_state = swe_pkg::ST_DIV;
                end
            end
            swe_pkg::ST_DIV: begin
                // restoring division by the counted total, one quotient bit a cycle
                n_rem  = rem_ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
                n_div  = {r_div[DW-2:0], rem_ge};
                n_step = r_step + STW'(1);
                if (r_step == STW'(DW - 1)) begin
                    n_state = swe_pkg::ST_DONE;
                end
            end
            swe_pkg::ST_DONE: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_out_ent   = ent_sat;
                    n_out_full  = full_now;
                    n_out_trig  = full_now && (ent_sat <= i_cuts.trigger_cut);
                    n_out_high  = full_now && (ent_sat > i_cuts.extend_cut);
                    n_state     = swe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swe_pkg::ST_IDLE;
            for (int k = 0; k < WINDOW; k++) begin
                r_win[k] <= swe_pkg::NOT_COUNTED;
            end
            for (int k = 0; k < NL; k++) begin
                r_cnt[k] <= '0;
            end
            r_fill      <= '0;
            r_total     <= '0;
            r_sum       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_win       <= n_win;
            r_cnt       <= n_cnt;
            r_fill      <= n_fill;
            r_total     <= n_total;
            r_sum       <= n_sum;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_old      <= n_old;
        r_num      <= n_num;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_out_ent  <= n_out_ent;
        r_out_full <= n_out_full;
        r_out_trig <= n_out_trig;
        r_out_high <= n_out_high;
    end

    a_pop_starts_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item_valid && o_item_ready) |=> (r_state == swe_pkg::ST_DEC))
        else $error("queue pop did not start the count update");

    a_total_within_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= r_fill)
        else $error("counted total exceeds window occupancy");

    a_empty_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total == '0) |-> (r_sum == '0))
        else $error("log sum not zero with no counted residues");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == swe_pkg::ST_DONE))
        else $error("result register loaded outside the final step");

endmodule

// ----- hw/rtl/sliding_window_entropy.sv -----
// sliding_window_entropy: top level with configuration registers, front queue and back engine
// depends on swe_pkg, swe_in_if, swe_out_if, swe_front and swe_back
//
// Takes one residue byte per transaction and returns one result per residue: the Shannon
// entropy of the letters counted in the last WINDOW bytes (16 fraction bits, rounded to
// nearest), a window-full flag and the trigger and high flags against the two cut registers.
// A seq_start transaction clears the window before its residue is taken. Each residue passes
// through the back engine's count update, numerator, rounding, bit-serial divider (23
// quotient bits, one a cycle) and result load; a window with no counted letters skips the
// divider. A two-entry queue after the input classifier and an output register let input and
// output stall on their own, so the next residue is taken while a finished result waits. Cut
// registers are written through i_cfg_we, i_cfg_index (0 trigger cut, 1 extend cut) and
// i_cfg_data; the user is to write them only while idle, the block does not enforce it.

module sliding_window_entropy #(
    parameter int WINDOW = swe_pkg::WINDOW_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    swe_in_if.sink                          i_in,
    swe_out_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  swe_pkg::t_cfg_idx               i_cfg_index,
    input  logic [swe_pkg::CUT_W-1:0]       i_cfg_data
);

    swe_pkg::t_swe_cuts r_cuts;
    logic               item_valid;
    logic               item_ready;
    swe_pkg::t_swe_item item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cuts.trigger_cut <= swe_pkg::TRIGGER_CUT_RST;
            r_cuts.extend_cut  <= swe_pkg::EXTEND_CUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                swe_pkg::CFG_TRIGGER_CUT: r_cuts.trigger_cut <= i_cfg_data;
                swe_pkg::CFG_EXTEND_CUT:  r_cuts.extend_cut  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    swe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_ready (item_ready)
    );

    swe_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_ready (item_ready),
        .i_cuts       (r_cuts),
        .o_res        (o_res)
    );

endmodule

// ----- sim/tb_sliding_window_entropy.sv -----
// tb_sliding_window_entropy: self-checking bench for the sliding window entropy block
// drives residues through swe_in_if, predicts entropy and flags per residue, checks swe_out_if
// depends on swe_pkg, swe_in_if, swe_out_if and sliding_window_entropy

module tb_sliding_window_entropy;

    localparam int WINDOW    = swe_pkg::WINDOW_DEFAULT;
    localparam int RES_W     = swe_pkg::RES_W;
    localparam int ENT_W     = swe_pkg::ENT_W;
    localparam int CUT_W     = swe_pkg::CUT_W;
    localparam int NLETTERS  = swe_pkg::NLETTERS;
    localparam int CUT_MAX   = (1 << CUT_W) - 1;
    localparam int CYCLE_CAP = 800000;
    localparam int HOLD_AT   = 250;
    localparam int HOLD_LEN  = 500;
    localparam logic [8*NLETTERS-1:0] AMINO = "ACDEFGHIKLMNPQRSTVWY";

    typedef struct packed {
        logic [RES_W-1:0] residue;
        logic             seq_start;
    } t_residue_item;

    typedef struct packed {
        logic [ENT_W-1:0] entropy_bits;
        logic             window_full;
        logic             is_trigger;
        logic             is_high;
    } t_window_result;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_EVERY4,
        RX_MOSTLY
    } t_rx_pattern;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    swe_pkg::t_cfg_idx i_cfg_index;
    logic [CUT_W-1:0]  i_cfg_data;

    swe_in_if  in_if ();
    swe_out_if out_if ();

    sliding_window_entropy #(.WINDOW(WINDOW)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_res       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // pending residues and expected results
    t_residue_item  residue_queue[$];
    t_window_result expected_results[$];

    // predicted window state
    swe_pkg::t_code   win_codes[WINDOW];
    logic [3:0]       win_counts[NLETTERS];
    int               win_fill;
    logic [CUT_W-1:0] trigger_cut;
    logic [CUT_W-1:0] extend_cut;

    int mismatch_count;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // log2(n) scaled by 2^32, rounded
    function automatic logic [63:0] log2_q32(input int n);
        case (n)
            2:       return 64'd4294967296;
            3:       return 64'd6807362106;
            4:       return 64'd8589934592;
            5:       return 64'd9972605231;
            6:       return 64'd11102329402;
            7:       return 64'd12057497579;
            8:       return 64'd12884901888;
            9:       return 64'd13614724212;
            10:      return 64'd14267572527;
            11:      return 64'd14858145665;
            12:      return 64'd15397296698;
            13:      return 64'd15893267570;
            14:      return 64'd16352464875;
            15:      return 64'd16779967337;
            default: return 64'd0;
        endcase
    endfunction

    function automatic swe_pkg::t_code letter_code(input logic [RES_W-1:0] b);
        logic [RES_W-1:0] up;
        up = (b >= "a" && b <= "z") ? b - 8'd32 : b;
        for (int k = 0; k < NLETTERS; k++) begin
            if (AMINO[8*(NLETTERS-1-k) +: 8] == up) return swe_pkg::t_code'(k);
        end
        return swe_pkg::NOT_COUNTED;
    endfunction

    task automatic clear_window();
        foreach (win_codes[k]) win_codes[k] = swe_pkg::NOT_COUNTED;
        foreach (win_counts[k]) win_counts[k] = '0;
        win_fill = 0;
    endtask

    // shift one residue into the window and queue the expected result
    task automatic advance_window(input t_residue_item it);
        swe_pkg::t_code c;
        swe_pkg::t_code gone;
        logic [63:0]    tot;
        logic [63:0]    acc;
        logic [63:0]    num;
        logic [63:0]    q;
        logic           full;
        t_window_result r;
        c = letter_code(it.residue);
        if (it.seq_start) clear_window();
        gone = win_codes[WINDOW-1];
        if (gone != swe_pkg::NOT_COUNTED && win_counts[gone] != 0) win_counts[gone]--;
        for (int k = WINDOW - 1; k > 0; k--) win_codes[k] = win_codes[k-1];
        win_codes[0] = c;
        if (c != swe_pkg::NOT_COUNTED && win_counts[c] != 4'd15) win_counts[c]++;
        if (win_fill < WINDOW) win_fill++;
        tot = '0;
        acc = '0;
        for (int k = 0; k < NLETTERS; k++) begin
            tot += 64'(win_counts[k]);
            acc += 64'(win_counts[k]) * log2_q32(int'(win_counts[k]));
        end
        if (tot == 0) begin
            q = '0;
        end else begin
            num = tot * log2_q32(int'(tot));
            num = (num > acc) ? num - acc : 64'd0;
            q = (num + tot * 64'd32768) / (tot * 64'd65536);
            if (q > CUT_MAX) q = CUT_MAX;
        end
        full = (win_fill >= WINDOW);
        r.entropy_bits = q[ENT_W-1:0];
        r.window_full  = full;
        r.is_trigger   = full && (q[ENT_W-1:0] <= trigger_cut);
        r.is_high      = full && (q[ENT_W-1:0] > extend_cut);
        expected_results.push_back(r);
    endtask

    task automatic push_residue(input logic [RES_W-1:0] b, input logic s);
        t_residue_item it;
        it.residue   = b;
        it.seq_start = s;
        residue_queue.push_back(it);
    endtask

    task automatic push_text(input string txt, input logic start_first);
        for (int k = 0; k < txt.len(); k++) push_residue(txt[k], start_first && k == 0);
    endtask

    // mostly well-formed sequences over a narrow or wide alphabet, some noise and short ones
    task automatic fill_random_phase(input int target);
        int               made;
        int               len;
        int               alpha;
        int               base;
        int               kind;
        logic [RES_W-1:0] b;
        made = 0;
        while (made < target) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    push_residue(RES_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
                len   = (kind == 1) ? $urandom_range(1, WINDOW - 1) : $urandom_range(WINDOW, 48);
                alpha = ($urandom_range(0, 2) == 0) ? $urandom_range(1, NLETTERS)
                                                    : $urandom_range(1, 4);
                base  = $urandom_range(0, NLETTERS - 1);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        b = RES_W'($urandom_range(0, 255));
                    end else begin
                        b = AMINO[8*(NLETTERS-1-((base + $urandom_range(0, alpha - 1)) % NLETTERS))
                                  +: 8];
                        if ($urandom_range(0, 1) == 1) b = b + 8'd32;
                    end
                    push_residue(b, k == 0);
                end
            end
            made += len;
        end
    endtask

    task automatic write_cut(input swe_pkg::t_cfg_idx idx, input logic [CUT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == swe_pkg::CFG_TRIGGER_CUT) trigger_cut = val;
        else extend_cut = val;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (residue_queue.size() != 0 || in_if.valid || expected_results.size() != 0);
    endtask

    // sender: bursts of random length, random gaps between them
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.residue   <= '0;
            in_if.seq_start <= 1'b0;
            burst_left = $urandom_range(1, 30);
            gap_left   = 0;
        end else begin
            if (in_if.valid && in_if.ready) advance_window('{in_if.residue, in_if.seq_start});
            if (!in_if.valid || in_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (residue_queue.size() != 0) begin
                    t_residue_item it;
                    it = residue_queue.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.residue   <= it.residue;
                    in_if.seq_start <= it.seq_start;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: own stall pattern, one long hold-off to back the block up
    t_rx_pattern rx_pattern;
    int          rx_left;
    int          rx_count;
    int          hold_left;
    bit          hold_done;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_pattern = RX_ALWAYS;
            rx_left    = 0;
            rx_count   = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) rx_count++;
            if (hold_left != 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (!hold_done && rx_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                out_if.ready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_pattern = t_rx_pattern'($urandom_range(0, 3));
                    rx_left    = $urandom_range(20, 200);
                end else begin
                    rx_left--;
                end
                case (rx_pattern)
                    RX_ALWAYS: out_if.ready <= 1'b1;
                    RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
                    RX_EVERY4: out_if.ready <= (rx_left % 4 == 0);
                    default:   out_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, actual %0d flags %b%b%b",
                         $time, out_if.entropy_bits, out_if.window_full, out_if.is_trigger,
                         out_if.is_high);
                mismatch_count++;
            end else begin
                t_window_result want;
                want = expected_results.pop_front();
                if (out_if.entropy_bits !== want.entropy_bits) begin
                    $display("%0t: entropy_bits expected %0d actual %0d",
                             $time, want.entropy_bits, out_if.entropy_bits);
                    mismatch_count++;
                end
                if (out_if.window_full !== want.window_full) begin
                    $display("%0t: window_full expected %b actual %b",
                             $time, want.window_full, out_if.window_full);
                    mismatch_count++;
                end
                if (out_if.is_trigger !== want.is_trigger) begin
                    $display("%0t: is_trigger expected %b actual %b",
                             $time, want.is_trigger, out_if.is_trigger);
                    mismatch_count++;
                end
                if (out_if.is_high !== want.is_high) begin
                    $display("%0t: is_high expected %b actual %b",
                             $time, want.is_high, out_if.is_high);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [CUT_W-1:0] tc;
        logic [CUT_W-1:0] ec;
        mismatch_count  = 0;
        cycle_count     = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = swe_pkg::CFG_TRIGGER_CUT;
        i_cfg_data      = '0;
        in_if.valid     = 1'b0;
        in_if.residue   = '0;
        in_if.seq_start = 1'b0;
        out_if.ready    = 1'b0;
        clear_window();
        trigger_cut = swe_pkg::TRIGGER_CUT_RST;
        extend_cut  = swe_pkg::EXTEND_CUT_RST;

        // no seq_start yet: byte extremes, uncounted neighbors of letters, both cases
        push_residue(8'h00, 1'b0);
        push_residue(8'hFF, 1'b0);
        push_text("aZb@[", 1'b0);
        push_residue(8'h60, 1'b0);
        push_text("{yWJ", 1'b0);
        // one letter filling the window in both cases: zero entropy, trigger
        push_text("MmMmMmMmMmMm", 1'b1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin tc = '0; ec = CUT_W'(CUT_MAX); end
                1: begin tc = CUT_W'(CUT_MAX); ec = '0; end
                2: begin
                    tc = CUT_W'($urandom_range(0, CUT_MAX));
                    ec = CUT_W'($urandom_range(0, CUT_MAX));
                end
                3: begin
                    tc = CUT_W'($urandom_range(60000, 240000));
                    ec = CUT_W'($urandom_range(60000, 240000));
                end
                default: begin
                    tc = swe_pkg::TRIGGER_CUT_RST;
                    ec = swe_pkg::EXTEND_CUT_RST;
                end
            endcase
            write_cut(swe_pkg::CFG_TRIGGER_CUT, tc);
            write_cut(swe_pkg::CFG_EXTEND_CUT, ec);
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            @(negedge i_clk);
            fill_random_phase(360);
            wait_idle();
        end

        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/swe_pkg.sv
hw/rtl/swe_in_if.sv
hw/rtl/swe_out_if.sv
hw/rtl/swe_front.sv
hw/rtl/swe_back.sv
hw/rtl/sliding_window_entropy.sv
sim/tb_sliding_window_entropy.sv
